// ----- hdl/rgbhsv_pkg.sv -----
// shared constants and types for the rgb to hsv pixel converter
// no dependencies; used by rgb_to_hsv_8bit
package rgbhsv_pkg;

  localparam int PIX_W     = 8;   // bits per color component
  localparam int QUO_W     = 8;   // quotient bits of both divisions
  localparam int NUM_W     = 16;  // dividend width, holds 255 * 255
  localparam int DIV_STEPS = 2;   // quotient bits resolved per divider stage

  localparam logic [7:0] HUE_SCALE = 8'd43;
  localparam logic [7:0] SAT_SCALE = 8'd255;
  localparam logic [7:0] OFF_RED   = 8'd0;
  localparam logic [7:0] OFF_GREEN = 8'd85;
  localparam logic [7:0] OFF_BLUE  = 8'd171;

  // which component is the maximum, red wins ties over green, green over blue
  typedef enum logic [1:0] {
    SEC_RED   = 2'd0,
    SEC_GREEN = 2'd1,
    SEC_BLUE  = 2'd2
  } sector_t;

  // hue bookkeeping that rides along with the hue division
  typedef struct packed {
    sector_t sector;
    logic    negative;
    logic    grey;
  } hue_side_t;

endpackage

// ----- hdl/rgbhsv_div.sv -----
// pipelined restoring divider, STEPS quotient bits per register stage
// carries a sideband word and a valid bit aligned with each division
// depends on nothing; instantiated by rgb_to_hsv_8bit
module rgbhsv_div #(
  parameter int NUM_W  = 16,
  parameter int DEN_W  = 8,
  parameter int QUO_W  = 8,
  parameter int STEPS  = 2,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              vld_i,
  input  logic [NUM_W-1:0]  num_i,
  input  logic [DEN_W-1:0]  den_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              vld_o,
  output logic [QUO_W-1:0]  quo_o,
  output logic [DEN_W-1:0]  rem_o,
  output logic [DEN_W-1:0]  den_o,
  output logic [SIDE_W-1:0] side_o
);

  localparam int STAGES = QUO_W / STEPS;
  // remainder must hold the dividend and the divisor shifted to the top quotient bit
  localparam int RW = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W;

  logic [RW-1:0]     rem_r  [STAGES];
  logic [QUO_W-1:0]  quo_r  [STAGES];
  logic [DEN_W-1:0]  den_r  [STAGES];
  logic [SIDE_W-1:0] side_r [STAGES];
  logic              vld_r  [STAGES];

  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    logic [RW-1:0]     rem_in;
    logic [QUO_W-1:0]  quo_in;
    logic [DEN_W-1:0]  den_in;
    logic [SIDE_W-1:0] side_in;
    logic              vld_in;
    logic [RW-1:0]     rem_nxt;
    logic [QUO_W-1:0]  quo_nxt;
    logic [RW-1:0]     trial;

    if (s == 0) begin : g_first
      assign rem_in  = RW'(num_i);
      assign quo_in  = '0;
      assign den_in  = den_i;
      assign side_in = side_i;
      assign vld_in  = vld_i;
    end else begin : g_next
      assign rem_in  = rem_r[s-1];
      assign quo_in  = quo_r[s-1];
      assign den_in  = den_r[s-1];
      assign side_in = side_r[s-1];
      assign vld_in  = vld_r[s-1];
    end

    // compare and subtract the shifted divisor, msb of the quotient first
    always_comb begin
      rem_nxt = rem_in;
      quo_nxt = quo_in;
      trial   = '0;
      for (int k = 0; k < STEPS; k++) begin
        trial = RW'(den_in) << (QUO_W - 1 - (s * STEPS + k));
        if (rem_nxt >= trial) begin
          rem_nxt = rem_nxt - trial;
          quo_nxt = {quo_nxt[QUO_W-2:0], 1'b1};
        end else begin
          quo_nxt = {quo_nxt[QUO_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else if (en) begin
        vld_r[s] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s]  <= rem_nxt;
        quo_r[s]  <= quo_nxt;
        den_r[s]  <= den_in;
        side_r[s] <= side_in;
      end
    end
  end

  assign vld_o  = vld_r[STAGES-1];
  assign quo_o  = quo_r[STAGES-1];
  assign rem_o  = rem_r[STAGES-1][DEN_W-1:0];
  assign den_o  = den_r[STAGES-1];
  assign side_o = side_r[STAGES-1];

endmodule

// ----- hdl/rgb_to_hsv_8bit.sv -----
// rgb to hsv pixel converter, top level
// depends on rgbhsv_pkg and rgbhsv_div
//
// Converts one 8-bit R,G,B pixel per clock, unless stalled, into 8-bit hue,
// saturation and brightness (the maximum component). Both divisions,
// 255*chroma/max and 43*|diff|/chroma, are exact and rounded to nearest with
// ties to even; hue wraps modulo 256. The pipeline takes a new pixel every
// cycle unless stalled and holds one result per stage: stages a and b, the
// two divider pipelines that resolve DIV_STEPS quotient bits per stage and
// the output register. An output stall freezes every stage in place.
module rgb_to_hsv_8bit #(
  parameter int DIV_STEPS = rgbhsv_pkg::DIV_STEPS
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_red,
  input  logic [7:0] in_green,
  input  logic [7:0] in_blue,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_hue,
  output logic [7:0] out_saturation,
  output logic [7:0] out_brightness
);

  localparam int PW = rgbhsv_pkg::PIX_W;
  localparam int QW = rgbhsv_pkg::QUO_W;
  localparam int NW = rgbhsv_pkg::NUM_W;
  localparam int HSW = $bits(rgbhsv_pkg::hue_side_t);

  logic en;

  // stage a: max, min, sector and difference magnitude
  logic [PW-1:0]        mx, mn, pos, neg;
  rgbhsv_pkg::sector_t  sector;
  logic                 a_vld_r;
  logic [PW-1:0]        a_mx_r, a_chroma_r, a_mag_r;
  rgbhsv_pkg::hue_side_t a_side_r;

  // stage b: scaled dividends
  logic                 b_vld_r;
  logic [NW-1:0]        b_sat_num_r, b_hue_num_r;
  logic [PW-1:0]        b_mx_r, b_chroma_r;
  rgbhsv_pkg::hue_side_t b_side_r;

  // divider outputs
  logic                 sd_vld, hd_vld;
  logic [QW-1:0]        sd_quo, hd_quo;
  logic [PW-1:0]        sd_rem, hd_rem, sd_den, hd_den;
  logic [0:0]           sd_black;
  logic [HSW-1:0]       hd_side_bits;
  rgbhsv_pkg::hue_side_t hd_side;

  // output stage
  logic                 sat_up, hue_up;
  logic [PW-1:0]        sat_q, hue_q, offset;
  logic [7:0]           hue_nxt, sat_nxt;
  logic                 out_valid_r;
  logic [7:0]           out_hue_r, out_sat_r, out_bright_r;

  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  always_comb begin
    mx = (in_red > in_green) ? in_red : in_green;
    mn = (in_red < in_green) ? in_red : in_green;
    if (in_blue > mx) begin
      mx = in_blue;
    end
    if (in_blue < mn) begin
      mn = in_blue;
    end
    if (mx == in_red) begin
      sector = rgbhsv_pkg::SEC_RED;
      pos    = in_green;
      neg    = in_blue;
    end else if (mx == in_green) begin
      sector = rgbhsv_pkg::SEC_GREEN;
      pos    = in_blue;
      neg    = in_red;
    end else begin
      sector = rgbhsv_pkg::SEC_BLUE;
      pos    = in_red;
      neg    = in_green;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
    end else if (en) begin
      a_vld_r <= in_valid;
      b_vld_r <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_mx_r            <= mx;
      a_chroma_r        <= mx - mn;
      a_mag_r           <= (neg > pos) ? neg - pos : pos - neg;
      a_side_r.sector   <= sector;
      a_side_r.negative <= neg > pos;
      a_side_r.grey     <= mx == mn;

      b_sat_num_r <= NW'(a_chroma_r) * NW'(rgbhsv_pkg::SAT_SCALE);
      b_hue_num_r <= NW'(a_mag_r) * NW'(rgbhsv_pkg::HUE_SCALE);
      b_mx_r      <= a_mx_r;
      b_chroma_r  <= a_chroma_r;
      b_side_r    <= a_side_r;
    end
  end

  rgbhsv_div #(
    .NUM_W  (NW),
    .DEN_W  (PW),
    .QUO_W  (QW),
    .STEPS  (DIV_STEPS),
    .SIDE_W (1)
  ) u_sat_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (b_vld_r),
    .num_i  (b_sat_num_r),
    .den_i  (b_mx_r),
    .side_i (b_mx_r == '0),
    .vld_o  (sd_vld),
    .quo_o  (sd_quo),
    .rem_o  (sd_rem),
    .den_o  (sd_den),
    .side_o (sd_black)
  );

  rgbhsv_div #(
    .NUM_W  (NW),
    .DEN_W  (PW),
    .QUO_W  (QW),
    .STEPS  (DIV_STEPS),
    .SIDE_W (HSW)
  ) u_hue_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (b_vld_r),
    .num_i  (b_hue_num_r),
    .den_i  (b_chroma_r),
    .side_i (b_side_r),
    .vld_o  (hd_vld),
    .quo_o  (hd_quo),
    .rem_o  (hd_rem),
    .den_o  (hd_den),
    .side_o (hd_side_bits)
  );

  assign hd_side = rgbhsv_pkg::hue_side_t'(hd_side_bits);

  // round to nearest, ties to even, from quotient and remainder
  always_comb begin
    sat_up = ({sd_rem, 1'b0} > {1'b0, sd_den}) ||
             (({sd_rem, 1'b0} == {1'b0, sd_den}) && sd_quo[0]);
    hue_up = ({hd_rem, 1'b0} > {1'b0, hd_den}) ||
             (({hd_rem, 1'b0} == {1'b0, hd_den}) && hd_quo[0]);
    sat_q  = PW'(sd_quo + QW'(sat_up));
    hue_q  = hd_side.grey ? '0 : PW'(hd_quo + QW'(hue_up));

    case (hd_side.sector)
      rgbhsv_pkg::SEC_RED:   offset = rgbhsv_pkg::OFF_RED;
      rgbhsv_pkg::SEC_GREEN: offset = rgbhsv_pkg::OFF_GREEN;
      rgbhsv_pkg::SEC_BLUE:  offset = rgbhsv_pkg::OFF_BLUE;
      default:               offset = rgbhsv_pkg::OFF_RED;
    endcase

    hue_nxt = hd_side.negative ? offset - hue_q : offset + hue_q;
    sat_nxt = sd_black[0] ? '0 : sat_q;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= sd_vld && hd_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_hue_r    <= hue_nxt;
      out_sat_r    <= sat_nxt;
      out_bright_r <= sd_den;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_hue        = out_hue_r;
  assign out_saturation = out_sat_r;
  assign out_brightness = out_bright_r;

endmodule
